@@ rtl/cfs_pkg.sv @@
// cfs_pkg: shared types and constants of the calibration sweep sequencer
// holds opcodes, record kinds, register indexes, the configuration struct and
// the stored record layout; used by every module of the block but cfs_rec_mem
`default_nettype none

package cfs_pkg;

   localparam int unsigned SAMPLES    = 16;
   localparam int unsigned SAMP_LOG   = $clog2(SAMPLES);
   localparam int unsigned SAMP_CNT_W = SAMP_LOG + 1;

   localparam int unsigned LOW_W    = 16;
   localparam int unsigned HIGH_W   = 16;
   localparam int unsigned FLOW_W   = 20;
   localparam int unsigned LSUM_W   = LOW_W + SAMP_LOG;
   localparam int unsigned HSUM_W   = HIGH_W + SAMP_LOG;
   localparam int unsigned FSUM_W   = FLOW_W + SAMP_LOG;
   localparam int unsigned COUNT_W  = 9;
   localparam int unsigned REC_IX_W = 8;
   localparam int unsigned REG_IX_W = 3;

   // opcodes
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_RESET = 2'd1;
   localparam logic [1:0] OP_START = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   // record kinds
   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_STORE = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   // register indexes
   localparam logic [REG_IX_W-1:0] REG_VALVE_START  = 3'd0;
   localparam logic [REG_IX_W-1:0] REG_BLOWER_START = 3'd1;
   localparam logic [REG_IX_W-1:0] REG_VALVE_STEP   = 3'd2;
   localparam logic [REG_IX_W-1:0] REG_BLOWER_STEP  = 3'd3;
   localparam logic [REG_IX_W-1:0] REG_BLOWER_LIMIT = 3'd4;
   localparam logic [REG_IX_W-1:0] REG_BLOWER_FINAL = 3'd5;
   localparam logic [REG_IX_W-1:0] REG_DWELL_MS     = 3'd6;
   localparam logic [REG_IX_W-1:0] REG_MAX_RECORDS  = 3'd7;

   typedef struct packed {
      logic [15:0] valve_start;
      logic [15:0] blower_start;
      logic [15:0] valve_step;
      logic [15:0] blower_step;
      logic [15:0] blower_limit;
      logic [15:0] blower_final;
      logic [31:0] dwell_ms;
      logic [7:0]  max_records;
   } cfg_type;

   typedef struct packed {
      logic [LOW_W-1:0]  low;
      logic [HIGH_W-1:0] high;
      logic [FLOW_W-1:0] flow;
   } rec_type;

endpackage

`default_nettype wire

@@ rtl/cfs_rec_mem.sv @@
// cfs_rec_mem: single-port-write, single-port-read record ram
// one write and one registered read per cycle; no dependencies
`default_nettype none

module cfs_rec_mem #(
   parameter int unsigned DEPTH = 256,
   parameter int unsigned WIDTH = 52
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] ram [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ram[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/cfs_core.sv @@
// cfs_core: sweep sequencer state machine, accumulators and result register
// depends on cfs_pkg and instantiates cfs_rec_mem for the record table
`default_nettype none

module cfs_core import cfs_pkg::*; #(
   parameter int unsigned TABLE_DEPTH = 256
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cfg_type             cfg,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [1:0]          req_opcode,
   input  wire logic [31:0]         req_now_ms,
   input  wire logic [FLOW_W-1:0]   req_flow_sample,
   input  wire logic [LOW_W-1:0]    req_sensor_low,
   input  wire logic [HIGH_W-1:0]   req_sensor_high,
   input  wire logic [REC_IX_W-1:0] req_read_index,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_running,
   output logic                     rsp_valve_strobe,
   output logic [15:0]              rsp_valve_value,
   output logic                     rsp_blower_strobe,
   output logic [15:0]              rsp_blower_value,
   output logic [1:0]               rsp_record_kind,
   output logic [REC_IX_W-1:0]      rsp_record_index,
   output logic [LOW_W-1:0]         rsp_rec_low,
   output logic [HIGH_W-1:0]        rsp_rec_high,
   output logic [FLOW_W-1:0]        rsp_rec_flow
);

   localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
   localparam int unsigned FILL_W = IDX_W + 1;

   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_READ} state_type;

   state_type state_ff, state_in;

   // captured transfer
   logic [1:0]          op_ff, op_in;
   logic [31:0]         now_ff, now_in;
   logic [FLOW_W-1:0]   flow_ff, flow_in;
   logic [LOW_W-1:0]    low_ff, low_in;
   logic [HIGH_W-1:0]   high_ff, high_in;
   logic [REC_IX_W-1:0] ridx_ff, ridx_in;

   // sweep state
   logic                  running_ff, running_in;
   logic [15:0]           valve_ff, valve_in;
   logic [15:0]           blower_ff, blower_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [31:0]           stamp_ff, stamp_in;
   logic [SAMP_CNT_W-1:0] samp_ff, samp_in;
   logic [LSUM_W-1:0]     lsum_ff, lsum_in;
   logic [HSUM_W-1:0]     hsum_ff, hsum_in;
   logic [FSUM_W-1:0]     fsum_ff, fsum_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_running_ff, rsp_running_in;
   logic                rsp_vstrobe_ff, rsp_vstrobe_in;
   logic [15:0]         rsp_valve_ff, rsp_valve_in;
   logic                rsp_bstrobe_ff, rsp_bstrobe_in;
   logic [15:0]         rsp_blower_ff, rsp_blower_in;
   logic [1:0]          rsp_kind_ff, rsp_kind_in;
   logic [REC_IX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [LOW_W-1:0]    rsp_low_ff, rsp_low_in;
   logic [HIGH_W-1:0]   rsp_high_ff, rsp_high_in;
   logic [FLOW_W-1:0]   rsp_flow_ff, rsp_flow_in;

   // ram interface
   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   rec_type          mem_wr_data;
   logic             mem_rd_en;
   logic [IDX_W-1:0] mem_rd_addr;
   rec_type          mem_rd_data;

   // datapath
   logic                  accept;
   logic                  out_free;
   logic [31:0]           elapsed;
   logic                  tick_go;
   logic [SAMP_CNT_W-1:0] samp_nx;
   logic                  record_done;
   logic [LSUM_W-1:0]     lsum_nx;
   logic [HSUM_W-1:0]     hsum_nx;
   logic [FSUM_W-1:0]     fsum_nx;
   logic [COUNT_W-1:0]    count_nx;
   logic                  sweep_end;
   logic                  valve_ok;
   logic                  blower_ok;
   logic [16:0]           blower_sum;
   logic [15:0]           blower_inc;
   logic [IDX_W-1:0]      wr_slot;
   logic [IDX_W-1:0]      rd_slot;
   logic                  rd_written;
   rec_type               rec_new;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign elapsed     = now_ff - stamp_ff;
   assign tick_go     = running_ff && (elapsed >= cfg.dwell_ms);
   assign samp_nx     = samp_ff + 1'b1;
   assign record_done = (samp_nx >= SAMP_CNT_W'(SAMPLES));
   assign lsum_nx     = lsum_ff + LSUM_W'(low_ff);
   assign hsum_nx     = hsum_ff + HSUM_W'(high_ff);
   assign fsum_nx     = fsum_ff + FSUM_W'(flow_ff);
   assign count_nx    = count_ff + 1'b1;
   assign sweep_end   = (count_nx > {1'b0, cfg.max_records});
   assign valve_ok    = (valve_ff >= cfg.valve_step);
   assign blower_ok   = (blower_ff <= cfg.blower_limit);
   assign blower_sum  = {1'b0, blower_ff} + {1'b0, cfg.blower_step};
   assign blower_inc  = blower_sum[16] ? 16'hFFFF : blower_sum[15:0];

   // slot is the index modulo the table depth
   assign wr_slot    = IDX_W'(count_ff);
   assign rd_slot    = IDX_W'(ridx_ff);
   // slots are filled from zero upwards, so the written ones form a prefix
   assign rd_written = ({1'b0, rd_slot} < fill_ff);

   // sum over a power-of-two sample count: the average is the upper bits
   assign rec_new.low  = lsum_nx[LSUM_W-1:SAMP_LOG];
   assign rec_new.high = hsum_nx[HSUM_W-1:SAMP_LOG];
   assign rec_new.flow = fsum_nx[FSUM_W-1:SAMP_LOG];

   assign mem_rd_en   = accept && (req_opcode == OP_READ);
   assign mem_rd_addr = IDX_W'(req_read_index);
   assign mem_wr_addr = wr_slot;
   assign mem_wr_data = rec_new;
   assign mem_wr_en   = (state_ff == S_EXEC) && out_free && (op_ff == OP_TICK)
                        && tick_go && record_done;

   always_comb begin
      logic        vstrobe;
      logic        bstrobe;
      logic [15:0] bcmd;

      vstrobe = 1'b0;
      bstrobe = 1'b0;
      bcmd    = blower_ff;

      state_in   = state_ff;
      op_in      = op_ff;
      now_in     = now_ff;
      flow_in    = flow_ff;
      low_in     = low_ff;
      high_in    = high_ff;
      ridx_in    = ridx_ff;
      running_in = running_ff;
      valve_in   = valve_ff;
      blower_in  = blower_ff;
      count_in   = count_ff;
      stamp_in   = stamp_ff;
      samp_in    = samp_ff;
      lsum_in    = lsum_ff;
      hsum_in    = hsum_ff;
      fsum_in    = fsum_ff;
      fill_in    = fill_ff;

      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_running_in = rsp_running_ff;
      rsp_vstrobe_in = rsp_vstrobe_ff;
      rsp_valve_in   = rsp_valve_ff;
      rsp_bstrobe_in = rsp_bstrobe_ff;
      rsp_blower_in  = rsp_blower_ff;
      rsp_kind_in    = rsp_kind_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_low_in     = rsp_low_ff;
      rsp_high_in    = rsp_high_ff;
      rsp_flow_in    = rsp_flow_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req_opcode;
               now_in   = req_now_ms;
               flow_in  = req_flow_sample;
               low_in   = req_sensor_low;
               high_in  = req_sensor_high;
               ridx_in  = req_read_index;
               state_in = (req_opcode == OP_READ) ? S_READ : S_EXEC;
            end
         end

         S_READ: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_running_in = running_ff;
               rsp_vstrobe_in = 1'b0;
               rsp_valve_in   = valve_ff;
               rsp_bstrobe_in = 1'b0;
               rsp_blower_in  = blower_ff;
               rsp_kind_in    = KIND_READ;
               rsp_index_in   = ridx_ff;
               rsp_low_in     = rd_written ? mem_rd_data.low  : '0;
               rsp_high_in    = rd_written ? mem_rd_data.high : '0;
               rsp_flow_in    = rd_written ? mem_rd_data.flow : '0;
               state_in       = S_IDLE;
            end
         end

         S_EXEC: begin
            if (out_free) begin
               rsp_kind_in  = KIND_NONE;
               rsp_index_in = '0;
               rsp_low_in   = '0;
               rsp_high_in  = '0;
               rsp_flow_in  = '0;

               case (op_ff)
                  OP_RESET: begin
                     running_in = 1'b0;
                     valve_in   = cfg.valve_start;
                     blower_in  = cfg.blower_start;
                     count_in   = '0;
                     stamp_in   = '0;
                     samp_in    = '0;
                     lsum_in    = '0;
                     hsum_in    = '0;
                     fsum_in    = '0;
                     fill_in    = '0;
                  end

                  OP_START: begin
                     vstrobe    = 1'b1;
                     bstrobe    = 1'b1;
                     bcmd       = blower_ff;
                     stamp_in   = now_ff;
                     running_in = 1'b1;
                  end

                  OP_TICK: begin
                     if (tick_go) begin
                        if (record_done) begin
                           rsp_kind_in  = KIND_STORE;
                           rsp_index_in = REC_IX_W'(wr_slot);
                           rsp_low_in   = rec_new.low;
                           rsp_high_in  = rec_new.high;
                           rsp_flow_in  = rec_new.flow;
                           samp_in      = '0;
                           lsum_in      = '0;
                           hsum_in      = '0;
                           fsum_in      = '0;
                           count_in     = count_nx;
                           stamp_in     = now_ff;
                           if ({1'b0, wr_slot} >= fill_ff) begin
                              fill_in = FILL_W'(wr_slot) + 1'b1;
                           end
                           if (sweep_end) begin
                              bstrobe    = 1'b1;
                              bcmd       = cfg.blower_final;
                              running_in = 1'b0;
                           end else if (valve_ok) begin
                              valve_in = valve_ff - cfg.valve_step;
                              vstrobe  = 1'b1;
                           end else if (blower_ok) begin
                              blower_in = blower_inc;
                              bstrobe   = 1'b1;
                              bcmd      = blower_inc;
                           end else begin
                              bstrobe    = 1'b1;
                              bcmd       = cfg.blower_final;
                              running_in = 1'b0;
                           end
                        end else begin
                           samp_in = samp_nx;
                           lsum_in = lsum_nx;
                           hsum_in = hsum_nx;
                           fsum_in = fsum_nx;
                        end
                     end
                  end

                  default: begin
                  end
               endcase

               rsp_valid_in   = 1'b1;
               rsp_running_in = running_in;
               rsp_vstrobe_in = vstrobe;
               rsp_valve_in   = valve_in;
               rsp_bstrobe_in = bstrobe;
               rsp_blower_in  = bstrobe ? bcmd : blower_in;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         running_ff   <= 1'b0;
         valve_ff     <= 16'd3000;
         blower_ff    <= 16'd35000;
         count_ff     <= '0;
         stamp_ff     <= '0;
         samp_ff      <= '0;
         lsum_ff      <= '0;
         hsum_ff      <= '0;
         fsum_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         valve_ff     <= valve_in;
         blower_ff    <= blower_in;
         count_ff     <= count_in;
         stamp_ff     <= stamp_in;
         samp_ff      <= samp_in;
         lsum_ff      <= lsum_in;
         hsum_ff      <= hsum_in;
         fsum_ff      <= fsum_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      now_ff         <= now_in;
      flow_ff        <= flow_in;
      low_ff         <= low_in;
      high_ff        <= high_in;
      ridx_ff        <= ridx_in;
      rsp_running_ff <= rsp_running_in;
      rsp_vstrobe_ff <= rsp_vstrobe_in;
      rsp_valve_ff   <= rsp_valve_in;
      rsp_bstrobe_ff <= rsp_bstrobe_in;
      rsp_blower_ff  <= rsp_blower_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_low_ff     <= rsp_low_in;
      rsp_high_ff    <= rsp_high_in;
      rsp_flow_ff    <= rsp_flow_in;
   end

   cfs_rec_mem #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH ($bits(rec_type))
   ) u_rec_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_running       = rsp_running_ff;
   assign rsp_valve_strobe  = rsp_vstrobe_ff;
   assign rsp_valve_value   = rsp_valve_ff;
   assign rsp_blower_strobe = rsp_bstrobe_ff;
   assign rsp_blower_value  = rsp_blower_ff;
   assign rsp_record_kind   = rsp_kind_ff;
   assign rsp_record_index  = rsp_index_ff;
   assign rsp_rec_low       = rsp_low_ff;
   assign rsp_rec_high      = rsp_high_ff;
   assign rsp_rec_flow      = rsp_flow_ff;

endmodule

`default_nettype wire

@@ rtl/flow_calibration_sweep_sequencer_unit.sv @@
// Calibration sweep sequencer, top level: configuration registers and core.
// Depends on cfs_pkg and cfs_core (which holds cfs_rec_mem).
//
// Usage:
//  - req_* carries one command per transfer (tick, reset, start, read record);
//    a transfer happens when req_valid is high and req_stall low.
//  - rsp_* returns exactly one result per command, transferred when rsp_valid
//    is high and rsp_stall low; the result sits in an output register.
//  - csr_* writes the eight sweep registers (index 0..7); csr_ready is always
//    high. Write them only while no command is outstanding.
// A command is captured at its transfer and run in the single execute step of
//  the sequencer (for a read, using the registered read of the record ram);
//  its result is then registered on rsp_*. No new command is taken until the
//  execute step is through, so commands do not overlap.
// A stalled result holds the next command in execution until the output
//  register frees; the command after that waits on req_stall.
// Reset (synchronous) stops the sweep, empties the record table at once
//  (written slots are tracked by a fill mark) and loads the register defaults.
// TABLE_DEPTH must be a power of two.
`default_nettype none

module flow_calibration_sweep_sequencer_unit import cfs_pkg::*; #(
   parameter int unsigned TABLE_DEPTH = 256
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [1:0]          req_opcode,
   input  wire logic [31:0]         req_now_ms,
   input  wire logic [FLOW_W-1:0]   req_flow_sample,
   input  wire logic [LOW_W-1:0]    req_sensor_low,
   input  wire logic [HIGH_W-1:0]   req_sensor_high,
   input  wire logic [REC_IX_W-1:0] req_read_index,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_running,
   output logic                     rsp_valve_strobe,
   output logic [15:0]              rsp_valve_value,
   output logic                     rsp_blower_strobe,
   output logic [15:0]              rsp_blower_value,
   output logic [1:0]               rsp_record_kind,
   output logic [REC_IX_W-1:0]      rsp_record_index,
   output logic [LOW_W-1:0]         rsp_rec_low,
   output logic [HIGH_W-1:0]        rsp_rec_high,
   output logic [FLOW_W-1:0]        rsp_rec_flow,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [REG_IX_W-1:0] csr_index,
   input  wire logic [31:0]         csr_wdata
);

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.valve_start  <= 16'd3000;
         cfg_ff.blower_start <= 16'd35000;
         cfg_ff.valve_step   <= 16'd50;
         cfg_ff.blower_step  <= 16'd500;
         cfg_ff.blower_limit <= 16'd40000;
         cfg_ff.blower_final <= 16'd5000;
         cfg_ff.dwell_ms     <= 32'd10000;
         cfg_ff.max_records  <= 8'd250;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_VALVE_START:  cfg_ff.valve_start  <= csr_wdata[15:0];
            REG_BLOWER_START: cfg_ff.blower_start <= csr_wdata[15:0];
            REG_VALVE_STEP:   cfg_ff.valve_step   <= csr_wdata[15:0];
            REG_BLOWER_STEP:  cfg_ff.blower_step  <= csr_wdata[15:0];
            REG_BLOWER_LIMIT: cfg_ff.blower_limit <= csr_wdata[15:0];
            REG_BLOWER_FINAL: cfg_ff.blower_final <= csr_wdata[15:0];
            REG_DWELL_MS:     cfg_ff.dwell_ms     <= csr_wdata;
            REG_MAX_RECORDS:  cfg_ff.max_records  <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   cfs_core #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_core (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_now_ms        (req_now_ms),
      .req_flow_sample   (req_flow_sample),
      .req_sensor_low    (req_sensor_low),
      .req_sensor_high   (req_sensor_high),
      .req_read_index    (req_read_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_running       (rsp_running),
      .rsp_valve_strobe  (rsp_valve_strobe),
      .rsp_valve_value   (rsp_valve_value),
      .rsp_blower_strobe (rsp_blower_strobe),
      .rsp_blower_value  (rsp_blower_value),
      .rsp_record_kind   (rsp_record_kind),
      .rsp_record_index  (rsp_record_index),
      .rsp_rec_low       (rsp_rec_low),
      .rsp_rec_high      (rsp_rec_high),
      .rsp_rec_flow      (rsp_rec_flow)
   );

endmodule

`default_nettype wire

@@ rtl/cfs_checker.sv @@
// cfs_checker: port-level assertions for the calibration sweep sequencer
// depends on cfs_pkg; bound to flow_calibration_sweep_sequencer_unit below
`default_nettype none

module cfs_checker import cfs_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire logic                rsp_running,
   input wire logic                rsp_valve_strobe,
   input wire logic                rsp_blower_strobe,
   input wire logic [1:0]          rsp_record_kind,
   input wire logic [REC_IX_W-1:0] rsp_record_index,
   input wire logic [LOW_W-1:0]    rsp_rec_low,
   input wire logic [HIGH_W-1:0]   rsp_rec_high,
   input wire logic [FLOW_W-1:0]   rsp_rec_flow
);

   // a stalled result stays valid and keeps its record kind and index
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_record_kind)
         && $stable(rsp_record_index))
      else $error("result changed while stalled");

   // no record shown means all record fields are zero
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_record_kind == KIND_NONE) |->
         (rsp_record_index == '0) && (rsp_rec_low == '0)
         && (rsp_rec_high == '0) && (rsp_rec_flow == '0))
      else $error("record fields not cleared on a plain result");

   // a read reply never commands an actuator
   a_read_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_record_kind == KIND_READ) |->
         !rsp_valve_strobe && !rsp_blower_strobe)
      else $error("actuator strobe on a read reply");

   // the valve is only commanded while the sweep runs
   a_valve_running: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valve_strobe |-> rsp_running)
      else $error("valve strobe while stopped");

endmodule

bind flow_calibration_sweep_sequencer_unit cfs_checker u_cfs_checker (.*);

`default_nettype wire
